// ----- design/dfcc_pkg.sv -----
// Shared types and constants for the DLE frame CRC-16 checker.
// No dependencies; imported by every module of the block.
package dfcc_pkg;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_SHORT   = 3'd1,
        ERR_HEADER  = 3'd2,
        ERR_CRC     = 3'd3,
        ERR_TRAILER = 3'd4,
        ERR_LONG    = 3'd5
    } t_err_code;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_beat;

    localparam int unsigned LEN_W         = 12;
    localparam logic [LEN_W-1:0] MIN_LEN_RESET = 12'd81;
    localparam int unsigned HEADER_BYTES  = 9;
    localparam int unsigned CRC_START_IDX = 6;   // byte index 2 leaves the delay line here

    localparam logic [15:0] CRC_POLY_REFL = 16'hA001;  // 0x8005 bit-reversed
    localparam logic [7:0]  BYTE_DLE      = 8'h10;
    localparam logic [7:0]  BYTE_STX      = 8'h02;
    localparam logic [7:0]  BYTE_ETX      = 8'h03;
    localparam logic [7:0]  BYTE_CMD_HI   = 8'h00;
    localparam logic [7:0]  BYTE_CMD_LO   = 8'h05;

endpackage

// ----- design/dfcc_crc16_byte.sv -----
// Byte-wide CRC-16/ARC update, eight reflected shift steps unrolled.
// Depends on dfcc_pkg for the reflected polynomial.
module dfcc_crc16_byte
    import dfcc_pkg::*;
(
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_data,
    output logic [15:0] o_crc
);

    always_comb begin
        logic [15:0] c;
        c = i_crc ^ {8'h00, i_data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REFL;
            end else begin
                c = c >> 1;
            end
        end
        o_crc = c;
    end

endmodule

// ----- design/dfcc_frame_core.sv -----
// Frame state (count, CRC, tail delay, header flag, overflow flag) and the result register.
// Depends on dfcc_pkg and dfcc_crc16_byte.
module dfcc_frame_core
    import dfcc_pkg::*;
#(
    parameter int unsigned MAX_FRAME_BYTES = 4095
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  t_beat            i_beat,
    input  logic [LEN_W-1:0] i_min_len,
    input  logic             i_out_ready,
    output logic             o_out_free,
    output logic             o_valid,
    output logic             o_frame_ok,
    output logic [2:0]       o_error_code,
    output logic [LEN_W-1:0] o_frame_length
);

    localparam int unsigned CW   = $clog2(MAX_FRAME_BYTES + 1);
    localparam int unsigned CMPW = (CW > LEN_W) ? CW : LEN_W;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_FRAME_BYTES);

    logic [CW-1:0] r_count, n_count;
    logic [15:0]   r_crc, n_crc;
    logic [7:0]    r_tail [4];
    logic [7:0]    n_tail [4];
    logic          r_hdr, n_hdr;
    logic          r_ovf, n_ovf;
    logic          r_o_valid;
    logic          r_o_ok;
    t_err_code     r_o_code, n_code;
    logic [LEN_W-1:0] r_o_len;

    logic [15:0]     crc_upd;
    logic            hdr_fail;
    logic [CMPW-1:0] cnt_ext;
    logic [CMPW-1:0] min_ext;

    dfcc_crc16_byte u_crc (
        .i_crc  (r_crc),
        .i_data (r_tail[3]),
        .o_crc  (crc_upd)
    );

    always_comb begin
        hdr_fail = ((r_count == CW'(0)) && (i_beat.data != BYTE_DLE))
                || ((r_count == CW'(1)) && (i_beat.data != BYTE_STX))
                || ((r_count == CW'(7)) && (i_beat.data != BYTE_CMD_HI))
                || ((r_count == CW'(8)) && (i_beat.data != BYTE_CMD_LO));
        n_hdr = r_hdr & ~hdr_fail;

        n_crc = (r_count >= CW'(CRC_START_IDX)) ? crc_upd : r_crc;

        n_tail[0] = i_beat.data;
        n_tail[1] = r_tail[0];
        n_tail[2] = r_tail[1];
        n_tail[3] = r_tail[2];

        if (r_count < CNT_MAX) begin
            n_count = r_count + CW'(1);
            n_ovf   = r_ovf;
        end else begin
            n_count = r_count;
            n_ovf   = 1'b1;
        end

        cnt_ext = CMPW'(n_count);
        min_ext = CMPW'(i_min_len);

        priority if (n_ovf) begin
            n_code = ERR_LONG;
        end else if (cnt_ext < min_ext) begin
            n_code = ERR_SHORT;
        end else if (!n_hdr || (n_count < CW'(HEADER_BYTES))) begin
            n_code = ERR_HEADER;
        end else if ((n_tail[3] != n_crc[7:0]) || (n_tail[2] != n_crc[15:8])) begin
            n_code = ERR_CRC;
        end else if ((n_tail[1] != BYTE_DLE) || (n_tail[0] != BYTE_ETX)) begin
            n_code = ERR_TRAILER;
        end else begin
            n_code = ERR_NONE;
        end
    end

    // frame state: a final byte returns everything to the reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= '0;
            r_hdr   <= 1'b1;
            r_ovf   <= 1'b0;
            for (int k = 0; k < 4; k++) r_tail[k] <= '0;
        end else if (i_go) begin
            if (i_beat.last) begin
                r_count <= '0;
                r_crc   <= '0;
                r_hdr   <= 1'b1;
                r_ovf   <= 1'b0;
                for (int k = 0; k < 4; k++) r_tail[k] <= '0;
            end else begin
                r_count <= n_count;
                r_crc   <= n_crc;
                r_hdr   <= n_hdr;
                r_ovf   <= n_ovf;
                for (int k = 0; k < 4; k++) r_tail[k] <= n_tail[k];
            end
        end
    end

    assign o_out_free = !r_o_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_go && i_beat.last) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go && i_beat.last) begin
            r_o_ok   <= (n_code == ERR_NONE);
            r_o_code <= n_code;
            r_o_len  <= cnt_ext[LEN_W-1:0];
        end
    end

    assign o_valid        = r_o_valid;
    assign o_frame_ok     = r_o_ok;
    assign o_error_code   = r_o_code;
    assign o_frame_length = r_o_len;

endmodule

// ----- design/dle_frame_crc16_checker_top.sv -----
// DLE frame checker with CRC-16/ARC: one byte per cycle, one verdict per frame.
// A final byte passes the input register, then the result register, before o_valid rises.
// Throughput: one byte per cycle; the byte-wide unrolled CRC update sits between the two registers.
// A non-final byte never waits on the output side; a final byte waits only while a verdict is held.
// Synchronous active-low reset clears frame state, the valid flags of both stages, and sets min_frame_length to 81.
// Depends on dfcc_pkg and dfcc_frame_core.
module dle_frame_crc16_checker_top
    import dfcc_pkg::*;
#(
    parameter int unsigned MAX_FRAME_BYTES = 4095
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_data_byte,
    input  logic             i_last_byte,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [LEN_W-1:0] i_cfg_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_frame_ok,
    output logic [2:0]       o_error_code,
    output logic [LEN_W-1:0] o_frame_length
);

    logic             r_s1_valid;
    t_beat            r_s1_beat;
    logic [LEN_W-1:0] r_min_len;
    logic             out_free;
    logic             s1_go;

    assign s1_go       = r_s1_valid && (!r_s1_beat.last || out_free);
    assign o_ready     = !r_s1_valid || s1_go;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= MIN_LEN_RESET;
        end else if (i_cfg_valid) begin
            r_min_len <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s1_beat.data <= i_data_byte;
            r_s1_beat.last <= i_last_byte;
        end
    end

    dfcc_frame_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_go           (s1_go),
        .i_beat         (r_s1_beat),
        .i_min_len      (r_min_len),
        .i_out_ready    (i_ready),
        .o_out_free     (out_free),
        .o_valid        (o_valid),
        .o_frame_ok     (o_frame_ok),
        .o_error_code   (o_error_code),
        .o_frame_length (o_frame_length)
    );

endmodule

// ----- design/dfcc_checker.sv -----
// Port-level checks on the verdict channel of the frame checker.
// Depends on dfcc_pkg; bound to dle_frame_crc16_checker_top below.
module dfcc_checker
    import dfcc_pkg::*;
#(
    parameter int unsigned MAX_FRAME_BYTES = 4095
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_valid,
    input logic             i_ready,
    input logic             o_frame_ok,
    input logic [2:0]       o_error_code,
    input logic [LEN_W-1:0] o_frame_length
);

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME_BYTES);

    a_ok_matches_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_frame_ok == (o_error_code == ERR_NONE)))
        else $error("frame_ok disagrees with error_code");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_error_code <= ERR_LONG))
        else $error("error_code out of range");

    a_long_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_error_code == ERR_LONG)) |-> (o_frame_length == MAX_LEN))
        else $error("overlong frame without saturated length");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_error_code)
                                   && $stable(o_frame_length)))
        else $error("stalled verdict changed");

endmodule

bind dle_frame_crc16_checker_top dfcc_checker #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
) u_dfcc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_frame_ok     (o_frame_ok),
    .o_error_code   (o_error_code),
    .o_frame_length (o_frame_length)
);
